// File: sv/pfq_pkg.sv
// Package: sizes, codes and the control/status structs of the priority queue.
`default_nettype none

package pfq_pkg;

    // Entries per level and number of levels
    localparam int DEPTH  = 16;
    localparam int LEVELS = 3;

    // Derived widths
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int LVL_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int ID_W    = 32;
    localparam int COUNT_W = 5;
    localparam int SLVL_W  = 2;
    localparam int REPORT_LEVELS = 3;

    // Highest legal priority request (1 is the top level)
    localparam logic [3:0] PRIO_MAX = 4'(LEVELS);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    typedef logic signed [ID_W-1:0] id_t;

    // Result status codes
    typedef enum logic [2:0] {
        ST_ENQUEUED = 3'd0,
        ST_SERVED   = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_BAD_PRIO = 3'd3,
        ST_FULL     = 3'd4
    } status_t;

    // Request codes
    typedef enum logic {
        REQ_ENQ = 1'b0,
        REQ_DEQ = 1'b1
    } req_t;

    // Commands from the top level to one level
    typedef struct packed {
        logic enq;
        logic deq;
        id_t  id;
    } level_ctrl_t;

    // What one level reports back
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] count_next;
        id_t              head;
    } level_stat_t;

endpackage

`default_nettype wire

// File: sv/three_level_priority_fifo.sv
// The result is registered at the edge that accepts its item.
// Throughput: one item per cycle while results are taken; a result held back by the
// receiver stops the input until it leaves. Each level is a chain of cells that all
// shift together on removal.
// Reset clears the level counts and the result valid; cell contents are not
// cleared and are read only while the count shows them filled.
`default_nettype none

module three_level_priority_fifo (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic                       req_type,
    input  wire logic [2:0]                 priority_req,
    input  wire pfq_pkg::id_t               entry_id,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [2:0]                      status,
    output pfq_pkg::id_t                    served_id,
    output logic [pfq_pkg::SLVL_W-1:0]      served_level,
    output logic [pfq_pkg::COUNT_W-1:0]     count_high,
    output logic [pfq_pkg::COUNT_W-1:0]     count_mid,
    output logic [pfq_pkg::COUNT_W-1:0]     count_low
);
    import pfq_pkg::*;

    level_ctrl_t ctrl [LEVELS];
    level_stat_t stat [LEVELS];

    logic              accept;
    logic              prio_ok;
    logic [LEVELS-1:0] enq_hit;
    logic [LEVELS-1:0] deq_hit;
    logic [LEVELS-1:0] lvl_full;
    logic              any_full;
    logic              found;
    logic [LVL_W-1:0]  sel;
    id_t               head_sel;
    logic [COUNT_W-1:0] cnt_out [REPORT_LEVELS];

    logic               out_valid_reg, out_valid_next;
    status_t            status_reg, status_next;
    id_t                served_id_reg, served_id_next;
    logic [SLVL_W-1:0]  served_level_reg, served_level_next;
    logic [COUNT_W-1:0] cnt_reg [REPORT_LEVELS];

    // Handshake: output register frees the input side
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // Priority decode and full flags
    assign prio_ok = (priority_req != 3'd0) && ({1'b0, priority_req} <= PRIO_MAX);

    always_comb
    begin
        for (int l = 0; l < LEVELS; l++)
        begin
            enq_hit[l]  = prio_ok && ({1'b0, priority_req} == 4'(l + 1));
            lvl_full[l] = (stat[l].count == CNT_FULL);
        end
    end

    assign any_full = |(enq_hit & lvl_full);

    // Pick the first non-empty level
    always_comb
    begin
        found    = 1'b0;
        sel      = '0;
        deq_hit  = '0;
        head_sel = '0;
        for (int l = 0; l < LEVELS; l++)
        begin
            if (!found && (stat[l].count != '0))
            begin
                found      = 1'b1;
                sel        = LVL_W'(l);
                deq_hit[l] = 1'b1;
                head_sel   = stat[l].head;
            end
        end
    end

    // Level commands
    for (genvar l = 0; l < LEVELS; l++)
    begin : g_level
        assign ctrl[l].enq = accept && (req_t'(req_type) == REQ_ENQ) && enq_hit[l]
                             && !lvl_full[l];
        assign ctrl[l].deq = accept && (req_t'(req_type) == REQ_DEQ) && deq_hit[l];
        assign ctrl[l].id  = entry_id;

        pfq_level u_level (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (ctrl[l]),
            .stat  (stat[l])
        );
    end

    // Counts as reported after this item
    for (genvar l = 0; l < REPORT_LEVELS; l++)
    begin : g_count
        if (l < LEVELS)
        begin : g_have
            assign cnt_out[l] = COUNT_W'(stat[l].count_next);
        end
        else
        begin : g_none
            assign cnt_out[l] = '0;
        end
    end

    // Result for the accepted item
    always_comb
    begin
        status_next       = status_reg;
        served_id_next    = served_id_reg;
        served_level_next = served_level_reg;
        out_valid_next    = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (accept)
        begin
            out_valid_next    = 1'b1;
            served_id_next    = '0;
            served_level_next = '0;
            if (req_t'(req_type) == REQ_ENQ)
            begin
                if (!prio_ok)
                begin
                    status_next = ST_BAD_PRIO;
                end
                else if (any_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    status_next = ST_ENQUEUED;
                end
            end
            else if (found)
            begin
                status_next       = ST_SERVED;
                served_id_next    = head_sel;
                served_level_next = SLVL_W'(sel);
            end
            else
            begin
                status_next = ST_EMPTY;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        status_reg       <= status_next;
        served_id_reg    <= served_id_next;
        served_level_reg <= served_level_next;
        for (int l = 0; l < REPORT_LEVELS; l++)
        begin
            if (accept)
            begin
                cnt_reg[l] <= cnt_out[l];
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign served_id    = served_id_reg;
    assign served_level = served_level_reg;
    assign count_high   = cnt_reg[0];
    assign count_mid    = cnt_reg[1];
    assign count_low    = cnt_reg[2];

    // Checks
    a_unserved_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg != ST_SERVED))
        |-> (served_id_reg == '0) && (served_level_reg == '0))
        else $error("served fields set without a served item");
    a_empty_report: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req_t'(req_type) == REQ_DEQ) && !found)
        |=> (status_reg == ST_EMPTY))
        else $error("empty dequeue not reported");
    a_deq_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(deq_hit))
        else $error("more than one level selected");
    a_full_report: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req_t'(req_type) == REQ_ENQ) && prio_ok && any_full)
        |=> (status_reg == ST_FULL))
        else $error("full level not reported");

endmodule

`default_nettype wire

// File: sv/pfq_cell.sv
// One storage cell of a level: holds an item ID, shifts toward the head on dequeue.
`default_nettype none

module pfq_cell (
    input  wire logic         clk,
    input  wire logic         shift,
    input  wire logic         load,
    input  wire pfq_pkg::id_t load_id,
    input  wire pfq_pkg::id_t next_id,
    output pfq_pkg::id_t      id
);
    import pfq_pkg::*;

    id_t id_reg;
    id_t id_next;

    // Take the neighbour's ID on a shift, the new ID on a load
    always_comb
    begin
        id_next = id_reg;
        if (shift)
        begin
            id_next = next_id;
        end
        else if (load)
        begin
            id_next = load_id;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg <= id_next;
    end

    assign id = id_reg;

endmodule

`default_nettype wire

// File: sv/pfq_level.sv
// One priority level: a shifting chain of cells with its fill count.
`default_nettype none

module pfq_level (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire pfq_pkg::level_ctrl_t ctrl,
    output pfq_pkg::level_stat_t      stat
);
    import pfq_pkg::*;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    id_t              cell_id [DEPTH];

    // Cell chain: cell 0 is the head, new items land at the fill count
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        id_t nbr_id;
        if (i == DEPTH - 1)
        begin : g_last
            assign nbr_id = cell_id[i];
        end
        else
        begin : g_mid
            assign nbr_id = cell_id[i + 1];
        end

        pfq_cell u_cell (
            .clk     (clk),
            .shift   (ctrl.deq),
            .load    (ctrl.enq && (count_reg == CNT_W'(i))),
            .load_id (ctrl.id),
            .next_id (nbr_id),
            .id      (cell_id[i])
        );
    end

    // Fill count
    always_comb
    begin
        count_next = count_reg;
        if (ctrl.enq)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctrl.deq)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign stat.count      = count_reg;
    assign stat.count_next = count_next;
    assign stat.head       = cell_id[0];

    // Checks
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("level count above depth");
    a_no_enq_full: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.enq |-> count_reg != CNT_FULL)
        else $error("store into full level");
    a_no_deq_empty: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.deq |-> count_reg != '0)
        else $error("removal from empty level");
    a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctrl.enq && ctrl.deq))
        else $error("store and removal together");

endmodule

`default_nettype wire
